// ----- src/asa_pkg.sv -----
// Shared types and constants for the multichannel ADC scan averager.
// No dependencies; every other file in src imports this package.
package asa_pkg;

  localparam int RAW_W       = 10;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CH_W        = 3;
  localparam int AVG_W       = 14;
  localparam int SUM_W       = 20;
  localparam int PROD_W      = RAW_W + CFG_W;
  localparam int DIV_STEPS   = 6;
  localparam int DIV_ITERS   = 4;
  localparam int QUO_W       = DIV_STEPS * DIV_ITERS;
  localparam int ITER_W      = $clog2(DIV_ITERS);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [CH_W-1:0]      NUM_CHANNELS = CH_W'(5);
  localparam logic [CH_W-1:0]      LAST_CHANNEL = NUM_CHANNELS - CH_W'(1);
  localparam logic [CH_W-1:0]      FIRST_CHANNEL = '0;
  localparam logic [CFG_W-1:0]     VREF_RESET = CFG_W'(5000);
  localparam logic [CFG_W-1:0]     DIVISOR_RESET = CFG_W'(1024);
  localparam logic [SUM_W-1:0]     SUM_MAX = '1;
  localparam logic [AVG_W-1:0]     AVG_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_VREF_MV = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = CFG_IDX_W'(1);

  typedef enum logic {
    KIND_SAMPLE,
    KIND_REPORT
  } kind_t;

  // One classified beat handed from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic [PROD_W-1:0] product;
    logic [CFG_W-1:0]  divisor;
    logic [CH_W-1:0]   channel;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- src/multichannel_adc_scan_averager_unit.sv -----
// Path: the switching beat is queued, popped into S_AVG, and its average is loaded
// into the result register once that register is free; each sample queued ahead
// first passes through the serial divider (4 iterations of 6 quotient bits). The back
// takes a new beat only as it finishes the last, and a 2-entry queue lets intake run
// ahead while a result waits. Reset (rst, synchronous) restores vref 5000 mV,
// divisor 1024, voltage channel, zero sum and count.
module multichannel_adc_scan_averager_unit #(
  parameter int SAMPLES_PER_CHANNEL = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [asa_pkg::RAW_W-1:0]     raw_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [asa_pkg::CH_W-1:0]      channel,
  output logic [asa_pkg::AVG_W-1:0]     average_mv,
  output logic                          frame_done
);
  import asa_pkg::*;

  fifo_ctl_t  fifo_ctl;
  fifo_stat_t fifo_stat;
  entry_t     wr_entry;
  entry_t     head;
  logic       fifo_push;
  logic       fifo_pop;

  assign fifo_ctl = {fifo_push, fifo_pop};

  asa_front #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .fifo_full  (fifo_stat.full),
    .push       (fifo_push),
    .entry      (wr_entry)
  );

  asa_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fifo_ctl),
    .wr_data (wr_entry),
    .rd_data (head),
    .stat    (fifo_stat)
  );

  asa_back #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_stat.empty),
    .head       (head),
    .pop        (fifo_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .average_mv (average_mv),
    .frame_done (frame_done)
  );

endmodule

// ----- src/asa_fifo.sv -----
// Two-entry flip-flop queue between the front and the back of the averager.
// Depends on asa_pkg for the entry type and depth.
module asa_fifo (
  input  logic              clk,
  input  logic              rst,
  input  asa_pkg::fifo_ctl_t ctl,
  input  asa_pkg::entry_t   wr_data,
  output asa_pkg::entry_t   rd_data,
  output asa_pkg::fifo_stat_t stat
);
  import asa_pkg::*;

  entry_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;

  assign stat.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= FIFO_PTR_W'((32'(wr_ptr) + 1) % FIFO_DEPTH);
      end
      if (ctl.pop) begin
        rd_ptr <= FIFO_PTR_W'((32'(rd_ptr) + 1) % FIFO_DEPTH);
      end
      unique case ({ctl.push, ctl.pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !ctl.push || ctl.pop)
    else $error("asa_fifo: push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !ctl.pop)
    else $error("asa_fifo: pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("asa_fifo: count out of range");
`endif

endmodule

// ----- src/asa_div.sv -----
// Serial restoring divider, several quotient bits per cycle.
// Depends on asa_pkg for dividend, divisor and step widths.
module asa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [asa_pkg::QUO_W-1:0] dividend,
  input  logic [asa_pkg::CFG_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [asa_pkg::QUO_W-1:0] quotient
);
  import asa_pkg::*;

  logic [QUO_W-1:0]  work;
  logic [QUO_W-1:0]  work_next;
  logic [CFG_W-1:0]  rem;
  logic [CFG_W-1:0]  rem_next;
  logic [CFG_W-1:0]  dsr;
  logic [ITER_W-1:0] iter;

  always_comb begin
    logic [CFG_W:0]   trial;
    logic [CFG_W-1:0] r;
    logic [QUO_W-1:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, w[QUO_W-1]};
      w     = {w[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        w[0]  = 1'b1;
      end
      r = trial[CFG_W-1:0];
    end
    rem_next  = r;
    work_next = w;
  end

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + ITER_W'(1);
      if (iter == ITER_W'(DIV_ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

endmodule

// ----- src/asa_front.sv -----
// Front of the averager: config registers, beat intake, product and scan sequencing.
// Depends on asa_pkg; pushes classified entries into asa_fifo.
module asa_front #(
  parameter int SAMPLES_PER_CHANNEL = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [asa_pkg::RAW_W-1:0]     raw_sample,
  input  logic                          fifo_full,
  output logic                          push,
  output asa_pkg::entry_t               entry
);
  import asa_pkg::*;

  localparam int IDX_W = $clog2(SAMPLES_PER_CHANNEL + 1);

  logic [CFG_W-1:0] vref_mv;
  logic [CFG_W-1:0] scale_divisor;
  logic [CH_W-1:0]  channel_index;
  logic [IDX_W-1:0] sample_index;
  logic             switching;

  assign in_stall  = fifo_full;
  assign push      = in_valid && !in_stall;
  assign switching = (sample_index == IDX_W'(SAMPLES_PER_CHANNEL));

  always_comb begin
    entry.kind    = switching ? KIND_REPORT : KIND_SAMPLE;
    entry.product = PROD_W'(raw_sample) * PROD_W'(vref_mv);
    // A zero divisor acts as one.
    entry.divisor = (scale_divisor == '0) ? CFG_W'(1) : scale_divisor;
    entry.channel = channel_index;
    entry.last    = (channel_index == LAST_CHANNEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv       <= VREF_RESET;
      scale_divisor <= DIVISOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VREF_MV:       vref_mv       <= cfg_data;
        REG_SCALE_DIVISOR: scale_divisor <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= FIRST_CHANNEL;
      sample_index  <= '0;
    end else if (push) begin
      if (switching) begin
        sample_index  <= '0;
        channel_index <= (channel_index == LAST_CHANNEL) ? FIRST_CHANNEL
                                                         : channel_index + CH_W'(1);
      end else begin
        sample_index <= sample_index + IDX_W'(1);
      end
    end
  end

endmodule

// ----- src/asa_back.sv -----
// Back of the averager: pops entries, scales samples through the serial divider,
// averages by reciprocal multiply, keeps the channel sum and holds the result
// register. Uses asa_pkg, asa_div.
module asa_back #(
  parameter int SAMPLES_PER_CHANNEL = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fifo_empty,
  input  asa_pkg::entry_t          head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [asa_pkg::CH_W-1:0] channel,
  output logic [asa_pkg::AVG_W-1:0] average_mv,
  output logic                     frame_done
);
  import asa_pkg::*;

  // sum / N as (sum * ceil(2^k / N)) >> k, exact for every 20-bit sum
  localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES_PER_CHANNEL);
  localparam int RECIP_W    = SUM_W + 2;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'(1) << AVG_SHIFT) + 64'(SAMPLES_PER_CHANNEL - 1)) /
             64'(SAMPLES_PER_CHANNEL));

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_AVG
  } state_t;

  state_t           state;
  kind_t            cur_kind;
  logic [CH_W-1:0]  cur_channel;
  logic             cur_last;
  logic [SUM_W-1:0] channel_sum;
  logic [SUM_W-1:0] channel_sum_next;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [QUO_W-1:0] div_dividend;
  logic [CFG_W-1:0] div_divisor;
  logic [QUO_W-1:0] quotient;

  logic                  out_free;
  logic                  finishing;
  logic [SUM_W:0]        wide_sum;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [SUM_W-1:0]      avg_mean;
  logic [AVG_W-1:0]      avg;

  assign out_free  = !out_valid || !out_stall;
  assign finishing = ((state == S_DIV) && div_done) ||
                     ((state == S_AVG) && out_free);
  assign pop       = !fifo_empty && ((state == S_IDLE) || finishing);
  assign div_start = pop && (head.kind == KIND_SAMPLE);

  always_comb begin
    wide_sum = SUM_W'(0) + {1'b0, channel_sum} + (SUM_W + 1)'(quotient);
    channel_sum_next = channel_sum;
    if (finishing) begin
      if (cur_kind == KIND_SAMPLE) begin
        // Saturate at the top of the sum range.
        if (quotient > QUO_W'(SUM_MAX) || wide_sum > (SUM_W + 1)'(SUM_MAX)) begin
          channel_sum_next = SUM_MAX;
        end else begin
          channel_sum_next = wide_sum[SUM_W-1:0];
        end
      end else begin
        channel_sum_next = '0;
      end
    end
  end

  assign div_dividend = QUO_W'(head.product);
  assign div_divisor  = head.divisor;

  // The sum register already holds every sample of the channel while in S_AVG.
  assign avg_prod = AVG_PROD_W'(channel_sum) * AVG_PROD_W'(AVG_RECIP);
  assign avg_mean = SUM_W'(avg_prod >> AVG_SHIFT);
  assign avg      = (avg_mean > SUM_W'(AVG_MAX)) ? AVG_MAX : avg_mean[AVG_W-1:0];

  asa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      channel_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      channel_sum <= channel_sum_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (finishing && cur_kind == KIND_REPORT) begin
        out_valid  <= 1'b1;
        channel    <= cur_channel;
        average_mv <= avg;
        frame_done <= cur_last;
      end
      if (pop) begin
        state       <= (head.kind == KIND_SAMPLE) ? S_DIV : S_AVG;
        cur_kind    <= head.kind;
        cur_channel <= head.channel;
        cur_last    <= head.last;
      end else if (finishing) begin
        state <= S_IDLE;
      end
    end
  end

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("asa_back: divider restarted while busy");
  a_report_lands: assert property (@(posedge clk) disable iff (rst)
    finishing && cur_kind == KIND_REPORT |=>
      out_valid && channel == $past(cur_channel) && frame_done == $past(cur_last))
    else $error("asa_back: report not loaded into result register");
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    finishing && cur_kind == KIND_REPORT |=> channel_sum == '0 ||
      ($past(pop) && $past(head.kind) == KIND_SAMPLE))
    else $error("asa_back: channel sum not cleared after report");
  a_wait_in_div: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_busy)
    else $error("asa_back: divider busy while idle");
`endif

endmodule

// ----- sim/tb_multichannel_adc_scan_averager_unit.sv -----
// Self-checking bench for multichannel_adc_scan_averager_unit: raw conversions in,
// per-channel averages out, checked against an in-bench scan/average predictor.
// Depends on asa_pkg and the unit under test in src.
module tb_multichannel_adc_scan_averager_unit;
  import asa_pkg::*;

  localparam int SCAN_SAMPLES  = 16;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [CH_W-1:0]  ch;
    logic [AVG_W-1:0] avg;
    logic             done;
  } scan_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [RAW_W-1:0]     raw_sample = '0;
  logic                 out_stall = 1'b0;
  wire                  in_stall;
  wire                  out_valid;
  wire [CH_W-1:0]       channel;
  wire [AVG_W-1:0]      average_mv;
  wire                  frame_done;

  // predictor state and register shadow
  int unsigned      vref_cfg = VREF_RESET;
  int unsigned      div_cfg = DIVISOR_RESET;
  logic [CH_W-1:0]  scan_ch = FIRST_CHANNEL;
  int unsigned      samples_taken = 0;
  int unsigned      ch_sum = 0;

  logic [RAW_W-1:0] raw_backlog[$];
  scan_result_t     pending_averages[$];
  scan_result_t     oldest;
  int               in_gap_left = 0;
  int               stall_left = 0;
  int               fail_count = 0;
  int               cycle_count = 0;
  int               items_sent = 0;
  logic             calm = 1'b0;

  multichannel_adc_scan_averager_unit #(
    .SAMPLES_PER_CHANNEL(SCAN_SAMPLES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_sample(raw_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .channel(channel),
    .average_mv(average_mv),
    .frame_done(frame_done)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return '1;
      3: return RAW_W'($urandom_range(1000, 1023));
      default: return RAW_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Accumulate one scaled sample, or close the channel on the switching conversion.
  task automatic predict_scan(input logic [RAW_W-1:0] raw);
    int unsigned divisor;
    int unsigned scaled;
    int unsigned total;
    int unsigned mean;
    scan_result_t res;
    if (samples_taken < SCAN_SAMPLES) begin
      divisor = (div_cfg == 0) ? 1 : div_cfg;
      scaled = (raw * vref_cfg) / divisor;
      total = ch_sum + scaled;
      if (scaled > SUM_MAX || total > SUM_MAX) total = SUM_MAX;
      ch_sum = total;
      samples_taken++;
    end else begin
      mean = ch_sum / SCAN_SAMPLES;
      if (mean > AVG_MAX) mean = AVG_MAX;
      res.ch = scan_ch;
      res.avg = AVG_W'(mean);
      res.done = (scan_ch == LAST_CHANNEL);
      pending_averages.push_back(res);
      scan_ch = (scan_ch == LAST_CHANNEL) ? FIRST_CHANNEL : scan_ch + 1'b1;
      samples_taken = 0;
      ch_sum = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    if (idx == REG_VREF_MV) vref_cfg = value;
    else div_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every beat to be taken and every average to arrive, then let
  // the back end drain any sample still in flight.
  task automatic wait_idle();
    @(negedge clk);
    while (raw_backlog.size() > 0 || in_valid || pending_averages.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: hold the beat while stalled, then idle for a random gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_scan(raw_sample);
      if (!(in_valid && in_stall)) begin
        if (in_gap_left > 0) begin
          in_valid <= 1'b0;
          in_gap_left--;
        end else if (raw_backlog.size() > 0) begin
          in_valid <= 1'b1;
          raw_sample <= raw_backlog.pop_front();
          in_gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_averages.size() == 0) begin
          $display("%0t: unexpected average, channel %0d average_mv %0d frame_done %0d",
                   $time, channel, average_mv, frame_done);
          fail_count++;
        end else begin
          oldest = pending_averages.pop_front();
          if (channel !== oldest.ch) begin
            $display("%0t: channel mismatch, expected %0d actual %0d",
                     $time, oldest.ch, channel);
            fail_count++;
          end
          if (average_mv !== oldest.avg) begin
            $display("%0t: average_mv mismatch, expected %0d actual %0d",
                     $time, oldest.avg, average_mv);
            fail_count++;
          end
          if (frame_done !== oldest.done) begin
            $display("%0t: frame_done mismatch, expected %0d actual %0d",
                     $time, oldest.done, frame_done);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned count;
    int unsigned sel;
    logic [RAW_W-1:0] opening[17];
    opening = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512, 10'd1022, 10'd0,
                10'd1023, 10'd1023, 10'd0, 10'h3F0, 10'h00F, 10'd700, 10'd300,
                10'd1023, 10'd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // full voltage channel at reset scaling, closed by the switching beat
    @(negedge clk);
    foreach (opening[i]) raw_backlog.push_back(opening[i]);
    wait_idle();

    // zero divisor with full-scale reference: each sample overflows the sum
    write_reg(REG_VREF_MV, 8191);
    write_reg(REG_SCALE_DIVISOR, 0);
    @(negedge clk);
    repeat (8) raw_backlog.push_back('1);
    wait_idle();

    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 3);
      if (sel == 0 || sel == 1) begin
        case ($urandom_range(0, 4))
          0: write_reg(REG_VREF_MV, 0);
          1: write_reg(REG_VREF_MV, 8191);
          2: write_reg(REG_VREF_MV, 5000);
          3: write_reg(REG_VREF_MV, 1);
          default: write_reg(REG_VREF_MV, $urandom_range(0, 8191));
        endcase
      end
      if (sel == 0 || sel == 2) begin
        case ($urandom_range(0, 6))
          0: write_reg(REG_SCALE_DIVISOR, 0);
          1: write_reg(REG_SCALE_DIVISOR, 1);
          2: write_reg(REG_SCALE_DIVISOR, 512);
          3: write_reg(REG_SCALE_DIVISOR, 4096);
          4: write_reg(REG_SCALE_DIVISOR, 8191);
          5: write_reg(REG_SCALE_DIVISOR, 1024);
          default: write_reg(REG_SCALE_DIVISOR, $urandom_range(0, 8191));
        endcase
      end
      @(negedge clk);
      count = $urandom_range(10, 150);
      repeat (count) raw_backlog.push_back(pick_raw());
      items_sent += count;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- multichannel_adc_scan_averager_unit.f -----
src/asa_pkg.sv
src/asa_fifo.sv
src/asa_div.sv
src/asa_front.sv
src/asa_back.sv
src/multichannel_adc_scan_averager_unit.sv
sim/tb_multichannel_adc_scan_averager_unit.sv
